// File: rtl/acd_pkg.sv
// acd_pkg: shared types and constants of the alignment containment dedup block
// used by acd_cell and alignment_containment_dedup; no dependencies
package acd_pkg;

  // default number of table entries, one per cell
  localparam int unsigned TableDepthDef = 64;

  // request codes
  localparam logic FuncInsert = 1'b0;
  localparam logic FuncCheck  = 1'b1;

  // one alignment hit as stored in a cell
  typedef struct packed {
    logic [15:0] query_index;
    logic [23:0] subject_index;
    logic [23:0] subject_start;
    logic [23:0] subject_end;
    logic [23:0] query_start;
    logic [23:0] query_end;
  } entry_t;

  // request traveling down the cell chain
  typedef struct packed {
    logic   func;
    entry_t entry;
  } probe_t;

  // token state handed from cell to cell
  typedef struct packed {
    logic valid;
    logic contained;
  } token_t;

  // stored entry holds the probe in both ranges with equal indices
  function automatic logic entry_holds(entry_t stored, entry_t probe);
    logic same_key;
    logic subj_in;
    logic qry_in;
    same_key = (stored.query_index == probe.query_index) &&
               (stored.subject_index == probe.subject_index);
    subj_in  = (probe.subject_start >= stored.subject_start) &&
               (probe.subject_end <= stored.subject_end);
    qry_in   = (probe.query_start >= stored.query_start) &&
               (probe.query_end <= stored.query_end);
    return same_key && subj_in && qry_in;
  endfunction

endpackage

// File: rtl/acd_cell.sv
// acd_cell: one table entry plus one stage of the request chain
// depends on acd_pkg
module acd_cell #(
  parameter int unsigned CntW = 7,
  parameter int unsigned Idx  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] count_i,
  input  logic            wr_en_i,
  input  acd_pkg::entry_t wr_entry_i,
  input  acd_pkg::token_t tok_i,
  input  acd_pkg::probe_t probe_i,
  output acd_pkg::token_t tok_o,
  output acd_pkg::probe_t probe_o
);
  import acd_pkg::*;

  entry_t entry_q;
  probe_t probe_q;
  token_t tok_q, tok_d;
  logic   live;

  // entry is compared only once it has been written
  assign live = (count_i > CntW'(Idx));

  // fold this entry into the running containment flag
  always_comb begin
    tok_d           = tok_i;
    tok_d.contained = tok_i.contained | (live & entry_holds(entry_q, probe_i.entry));
  end

  // stage registers of the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_i;
  end

  // entry write at insertion
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_entry_i;
    end
  end

  assign tok_o   = tok_q;
  assign probe_o = probe_q;

endmodule

// File: rtl/alignment_containment_dedup.sv
// alignment_containment_dedup: containment filter over a table of alignment hits
// a request passes the registers of the TABLE_DEPTH cells, then the result registers
// one request at a time: busy holds off a new request until the previous one leaves
//   the chain of TABLE_DEPTH cells
// reset: asynchronous, empties the table (fill count zero); results cannot be stalled
// depends on acd_pkg and acd_cell
module alignment_containment_dedup #(
  parameter int unsigned TABLE_DEPTH = acd_pkg::TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [15:0] query_index_i,
  input  logic [23:0] subject_index_i,
  input  logic [23:0] subject_start_i,
  input  logic [23:0] subject_end_i,
  input  logic [23:0] query_start_i,
  input  logic [23:0] query_end_i,
  output logic        valid_o,
  output logic        inserted_o,
  output logic        contained_o,
  output logic        table_full_o,
  output logic [6:0]  stored_count_o
);
  import acd_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  logic            accept;
  logic            busy_q;
  logic [CntW-1:0] count_q, count_d;
  token_t          tok_in;
  probe_t          probe_in;
  token_t          tok_chain   [TABLE_DEPTH+1];
  probe_t          probe_chain [TABLE_DEPTH+1];
  token_t          tok_end;
  probe_t          probe_end;
  logic            has_room;
  logic            do_insert;
  logic            do_full;
  logic            valid_q;
  logic            inserted_q, contained_q, full_q;
  logic [CntW-1:0] out_count_q;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // request entering the first cell
  always_comb begin
    tok_in.valid                  = accept;
    tok_in.contained              = 1'b0;
    probe_in.func                 = func_i;
    probe_in.entry.query_index    = query_index_i;
    probe_in.entry.subject_index  = subject_index_i;
    probe_in.entry.subject_start  = subject_start_i;
    probe_in.entry.subject_end    = subject_end_i;
    probe_in.entry.query_start    = query_start_i;
    probe_in.entry.query_end      = query_end_i;
  end

  assign tok_chain[0]   = tok_in;
  assign probe_chain[0] = probe_in;

  // chain of cells, one per table entry
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    acd_cell #(
      .CntW(CntW),
      .Idx (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .count_i   (count_q),
      .wr_en_i   (do_insert && (count_q == CntW'(i))),
      .wr_entry_i(probe_end.entry),
      .tok_i     (tok_chain[i]),
      .probe_i   (probe_chain[i]),
      .tok_o     (tok_chain[i+1]),
      .probe_o   (probe_chain[i+1])
    );
  end

  assign tok_end   = tok_chain[TABLE_DEPTH];
  assign probe_end = probe_chain[TABLE_DEPTH];

  // decision when the request leaves the last cell
  assign has_room  = (count_q < CntW'(TABLE_DEPTH));
  assign do_insert = tok_end.valid && (probe_end.func == FuncInsert) &&
                     !tok_end.contained && has_room;
  assign do_full   = tok_end.valid && (probe_end.func == FuncInsert) &&
                     !tok_end.contained && !has_room;

  assign count_d = do_insert ? count_q + 1'b1 : count_q;

  // control state: busy flag, fill count, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tok_end.valid) begin
        busy_q <= 1'b0;
      end
      count_q <= count_d;
      valid_q <= tok_end.valid;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (tok_end.valid) begin
      inserted_q  <= do_insert;
      contained_q <= tok_end.contained;
      full_q      <= do_full;
      out_count_q <= count_d;
    end
  end

  assign valid_o        = valid_q;
  assign inserted_o     = inserted_q;
  assign contained_o    = contained_q;
  assign table_full_o   = full_q;
  assign stored_count_o = 7'(out_count_q);

  // checks on the control logic
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after accepted request");

  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !$past(accept))
    else $error("result strobe right after accepting a request");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("fill count above table depth");

  a_result_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $countones({inserted_o, contained_o, table_full_o}) <= 1)
    else $error("conflicting result flags");

endmodule

// File: verif/tb_alignment_containment_dedup.sv
// tb_alignment_containment_dedup: self-checking bench of the alignment containment filter
// runs a directed table, then random hits, and checks each result against the table or a predictor
// depends on acd_pkg and alignment_containment_dedup
`timescale 1ns / 1ps

module tb_alignment_containment_dedup;
  import acd_pkg::*;

  localparam int unsigned TABLE_DEPTH = TableDepthDef;
  localparam int unsigned RandomHits = 1030;

  // one result as the block reports it
  typedef struct packed {
    logic       inserted;
    logic       contained;
    logic       table_full;
    logic [6:0] stored_count;
  } verdict_t;

  // one row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic     func;
    entry_t   hit;
    logic     typed;
    verdict_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        func_i;
  logic [15:0] query_index_i;
  logic [23:0] subject_index_i;
  logic [23:0] subject_start_i;
  logic [23:0] subject_end_i;
  logic [23:0] query_start_i;
  logic [23:0] query_end_i;
  logic        valid_o;
  logic        inserted_o;
  logic        contained_o;
  logic        table_full_o;
  logic [6:0]  stored_count_o;

  // predictor copy of the hit table
  entry_t      held_hits[TABLE_DEPTH];
  int unsigned held_count;

  verdict_t    hit_verdicts[$];
  stim_row_t   dir_rows[$];
  logic [15:0] qi_pool[6];
  logic [23:0] si_pool[6];
  int unsigned mismatch_count;
  int unsigned nogap_left;

  alignment_containment_dedup #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .query_index_i  (query_index_i),
    .subject_index_i(subject_index_i),
    .subject_start_i(subject_start_i),
    .subject_end_i  (subject_end_i),
    .query_start_i  (query_start_i),
    .query_end_i    (query_end_i),
    .valid_o        (valid_o),
    .inserted_o     (inserted_o),
    .contained_o    (contained_o),
    .table_full_o   (table_full_o),
    .stored_count_o (stored_count_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic entry_t mk_hit(input logic [15:0] qi, input logic [23:0] si,
                                    input logic [23:0] ss, input logic [23:0] se,
                                    input logic [23:0] qs, input logic [23:0] qe);
    entry_t h;
    h.query_index   = qi;
    h.subject_index = si;
    h.subject_start = ss;
    h.subject_end   = se;
    h.query_start   = qs;
    h.query_end     = qe;
    return h;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // containment filter: compare against held hits, append in insert mode when new and room is left
  function automatic verdict_t predict_hit(input logic fn, input entry_t hit);
    verdict_t v;
    entry_t   s;
    v = '0;
    for (int unsigned i = 0; i < held_count; i++) begin
      s = held_hits[i];
      if (s.query_index == hit.query_index && s.subject_index == hit.subject_index &&
          hit.subject_start >= s.subject_start && hit.subject_end <= s.subject_end &&
          hit.query_start >= s.query_start && hit.query_end <= s.query_end) begin
        v.contained = 1'b1;
      end
    end
    if (fn == FuncInsert && !v.contained) begin
      if (held_count < TABLE_DEPTH) begin
        held_hits[held_count] = hit;
        held_count++;
        v.inserted = 1'b1;
      end else begin
        v.table_full = 1'b1;
      end
    end
    v.stored_count = 7'(held_count);
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // idle length: mostly short, a few long, and now and then a run with no idling
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (nogap_left > 0) begin
      nogap_left--;
      return 0;
    end
    if (r < 3) begin
      nogap_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 35) return 0;
    if (r < 90) return $urandom_range(1, 70);
    return $urandom_range(71, 300);
  endfunction

  // random hit: mostly near a held hit or on a pooled key, the rest pure noise
  function automatic entry_t make_probe();
    entry_t h;
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 5);
    if (r < 55 && held_count > 0) begin
      h = held_hits[$urandom_range(0, held_count - 1)];
      case ($urandom_range(0, 4))
        0: ;
        1: begin
          h.subject_start = h.subject_start + 24'($urandom_range(0, 3));
          h.subject_end   = h.subject_end - 24'($urandom_range(0, 3));
          h.query_start   = h.query_start + 24'($urandom_range(0, 3));
          h.query_end     = h.query_end - 24'($urandom_range(0, 3));
        end
        2: h.subject_start = h.subject_start - 24'd1;
        3: h.query_end = h.query_end + 24'd1;
        default: begin
          if ($urandom_range(0, 1)) h.query_index[$urandom_range(0, 15)] ^= 1'b1;
          else h.subject_index[$urandom_range(0, 23)] ^= 1'b1;
        end
      endcase
    end else if (r < 85) begin
      h.query_index   = qi_pool[k];
      h.subject_index = si_pool[k];
      h.subject_start = 24'($urandom);
      h.subject_end   = h.subject_start + 24'($urandom_range(0, 1000));
      h.query_start   = 24'($urandom);
      h.query_end     = h.query_start + 24'($urandom_range(0, 1000));
    end else begin
      h = mk_hit(16'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom), 24'($urandom));
    end
    return h;
  endfunction

  // drive one request from a falling edge, predict at acceptance, then idle
  task automatic send_hit(input logic fn, input entry_t hit, input logic typed,
                          input verdict_t want, input int unsigned gap);
    verdict_t pred;
    start           = 1'b1;
    func_i          = fn;
    query_index_i   = hit.query_index;
    subject_index_i = hit.subject_index;
    subject_start_i = hit.subject_start;
    subject_end_i   = hit.subject_end;
    query_start_i   = hit.query_start;
    query_end_i     = hit.query_end;
    do @(posedge clk_i); while (busy);
    pred = predict_hit(fn, hit);
    hit_verdicts.insert(hit_verdicts.size(), typed ? want : pred);
    @(negedge clk_i);
    if (gap > 0) begin
      start           = 1'b0;
      func_i          = 1'($urandom);
      query_index_i   = 16'($urandom);
      subject_index_i = 24'($urandom);
      subject_start_i = 24'($urandom);
      subject_end_i   = 24'($urandom);
      query_start_i   = 24'($urandom);
      query_end_i     = 24'($urandom);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (hit_verdicts.size() != 0) @(negedge clk_i);
  endtask

  // result checker: every strobe must match the oldest pending request
  always @(posedge clk_i) begin
    verdict_t w;
    if (rst_ni && valid_o) begin
      if (hit_verdicts.size() == 0) begin
        flag_mismatch("result with no request pending", 1, 0);
      end else begin
        w = hit_verdicts.pop_front();
        if (inserted_o !== w.inserted) flag_mismatch("inserted", inserted_o, w.inserted);
        if (contained_o !== w.contained) flag_mismatch("contained", contained_o, w.contained);
        if (table_full_o !== w.table_full)
          flag_mismatch("table_full", table_full_o, w.table_full);
        if (stored_count_o !== w.stored_count)
          flag_mismatch("stored_count", stored_count_o, w.stored_count);
      end
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t row;
    entry_t    h;
    rst_ni          = 1'b0;
    start           = 1'b0;
    func_i          = FuncInsert;
    query_index_i   = '0;
    subject_index_i = '0;
    subject_start_i = '0;
    subject_end_i   = '0;
    query_start_i   = '0;
    query_end_i     = '0;
    held_count      = 0;
    mismatch_count  = 0;
    nogap_left      = 0;

    // key pool for random hits, one of them at the extremes
    qi_pool[0] = 16'hFFFF;
    si_pool[0] = 24'hFFFFFF;
    for (int i = 1; i < 6; i++) begin
      qi_pool[i] = 16'($urandom);
      si_pool[i] = 24'($urandom);
    end

    // directed rows: func, hit, typed, {inserted, contained, table_full}, count
    // check-only on the empty table, then a full-range hit on the all-ones key
    add_row({FuncCheck, mk_hit(16'hFFFF, 24'hFFFFFF, 24'h0, 24'hFFFFFF,
             24'h0, 24'hFFFFFF), 1'b1, 3'b000, 7'd0});
    add_row({FuncInsert, mk_hit(16'hFFFF, 24'hFFFFFF, 24'h0, 24'hFFFFFF,
             24'h0, 24'hFFFFFF), 1'b1, 3'b100, 7'd1});
    // contained in insert mode and in check-only mode
    add_row({FuncInsert, mk_hit(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
             24'h0, 24'h0), 1'b1, 3'b010, 7'd1});
    add_row({FuncCheck, mk_hit(16'hFFFF, 24'hFFFFFF, 24'h123456, 24'h654321,
             24'd10, 24'd20), 1'b1, 3'b010, 7'd1});
    // hit equal to a held hit
    add_row({FuncInsert, mk_hit(16'hFFFF, 24'hFFFFFF, 24'h0, 24'hFFFFFF,
             24'h0, 24'hFFFFFF), 1'b1, 3'b010, 7'd1});
    // one index differs, so no comparison applies
    add_row({FuncInsert, mk_hit(16'hFFFE, 24'hFFFFFF, 24'd5, 24'd5,
             24'd5, 24'd5), 1'b1, 3'b100, 7'd2});
    add_row({FuncInsert, mk_hit(16'hFFFF, 24'hFFFFFE, 24'd5, 24'd5,
             24'd5, 24'd5), 1'b1, 3'b100, 7'd3});
    // reversed ranges on the all-zero key, compared as given
    add_row({FuncInsert, mk_hit(16'h0, 24'h0, 24'hFFFFFF, 24'h0,
             24'h800000, 24'h7FFFFF), 1'b1, 3'b100, 7'd4});
    add_row({FuncInsert, mk_hit(16'h0, 24'h0, 24'hFFFFFF, 24'h0,
             24'h800000, 24'h7FFFFF), 1'b1, 3'b010, 7'd4});
    add_row({FuncCheck, mk_hit(16'h0, 24'h0, 24'h0, 24'hFFFFFF,
             24'h800000, 24'h7FFFFF), 1'b1, 3'b000, 7'd4});
    // range edges one past a held hit
    add_row({FuncInsert, mk_hit(16'h0, 24'h0, 24'd100, 24'd200,
             24'd100, 24'd200), 1'b1, 3'b100, 7'd5});
    add_row({FuncInsert, mk_hit(16'h0, 24'h0, 24'd100, 24'd200,
             24'd99, 24'd200), 1'b1, 3'b100, 7'd6});
    add_row({FuncInsert, mk_hit(16'h0, 24'h0, 24'd100, 24'd201,
             24'd100, 24'd200), 1'b1, 3'b100, 7'd7});
    add_row({FuncCheck, mk_hit(16'h0, 24'h0, 24'd101, 24'd199,
             24'd101, 24'd199), 1'b1, 3'b010, 7'd7});
    // alternating bit patterns
    add_row({FuncInsert, mk_hit(16'hAAAA, 24'h555555, 24'h555555, 24'hAAAAAA,
             24'hAAAAAA, 24'h555555), 1'b1, 3'b100, 7'd8});
    add_row({FuncInsert, mk_hit(16'h5555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555,
             24'h555555, 24'hAAAAAA), 1'b1, 3'b100, 7'd9});
    add_row({FuncCheck, mk_hit(16'h5555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555,
             24'h555555, 24'hAAAAAA), 1'b1, 3'b010, 7'd9});
    add_row({FuncCheck, mk_hit(16'hFFFF, 24'hFFFFFF, 24'h0, 24'h0,
             24'hFFFFFF, 24'hFFFFFF), 1'b1, 3'b010, 7'd9});
    // left to the predictor
    add_row({FuncInsert, mk_hit(16'hFFFE, 24'hFFFFFF, 24'd4, 24'd6,
             24'd5, 24'd5), 1'b0, 3'b000, 7'd0});
    add_row({FuncCheck, mk_hit(16'hFFFE, 24'hFFFFFF, 24'd5, 24'd5,
             24'd5, 24'd5), 1'b0, 3'b000, 7'd0});

    // reset
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_hit(row.func, row.hit, row.typed, row.want, pick_gap());
    end
    @(negedge clk_i);
    start = 1'b0;
    wait_drained();

    // random part; the table fills early and stays full from then on
    for (int unsigned n = 0; n < RandomHits; n++) begin
      h = make_probe();
      send_hit(($urandom_range(0, 99) < 30) ? FuncCheck : FuncInsert, h, 1'b0, '0,
               (n == RandomHits - 1) ? 1 : pick_gap());
      if (n == RandomHits / 2) begin
        start = 1'b0;
        wait_drained();
      end
    end
    start = 1'b0;

    // drain and settle
    wait_drained();
    repeat (TABLE_DEPTH + 10) @(posedge clk_i);
    if (hit_verdicts.size() != 0)
      flag_mismatch("requests left without result", hit_verdicts.size(), 0);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/acd_pkg.sv
rtl/acd_cell.sv
rtl/alignment_containment_dedup.sv
verif/tb_alignment_containment_dedup.sv
